// ----- src/upe_pkg.sv -----
// Shared types and constants for the UDP payload extractor.
`timescale 1ns / 1ps

package upe_pkg;

   // Largest frame handled; the byte at offset MaxFrameBytes-1 closes the frame.
   localparam int unsigned MaxFrameBytes = 65536;

   localparam int unsigned OffsetWidth = 16;
   localparam int unsigned QueueDepth  = 4;
   localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

   // Link header kinds held in the csr register.
   localparam logic [1:0] LinkLoopback = 2'd0;
   localparam logic [1:0] LinkEthernet = 2'd1;
   localparam logic [1:0] LinkNone     = 2'd2;
   localparam logic [1:0] LinkReset    = LinkEthernet;

   localparam logic [3:0] LinkBytesLoopback = 4'd4;
   localparam logic [3:0] LinkBytesEthernet = 4'd14;

   localparam logic [3:0] IpVersion4  = 4'd4;
   localparam logic [3:0] IhlMin      = 4'd5;
   localparam logic [7:0] ProtoUdp    = 8'd17;
   localparam logic [15:0] UdpHdrBytes = 16'd8;

   // Offsets within the IP header and within the UDP header.
   localparam logic [15:0] IpVerOffset   = 16'd0;
   localparam logic [15:0] IpProtoOffset = 16'd9;
   localparam logic [15:0] UdpLenHiOff   = 16'd4;
   localparam logic [15:0] UdpLenLoOff   = 16'd5;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_last;
      logic       payload_short;
   } rsp_type;

endpackage

// ----- src/upe_front.sv -----
// Front end: tracks frame offsets, checks headers and picks out payload bytes.
`timescale 1ns / 1ps

module upe_front import upe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   input  logic       accept,
   input  req_type    req_data,
   output logic       push,
   output rsp_type    push_data
);

   localparam logic [OffsetWidth:0] EndOffset = (OffsetWidth + 1)'(MaxFrameBytes - 1);
   localparam logic [OffsetWidth-1:0] OffsetMax = '1;

   logic [1:0]             link_kind_ff;
   logic [OffsetWidth-1:0] byte_offset_ff, byte_offset_in;
   logic [5:0]             ip_hdr_bytes_ff, ip_hdr_bytes_in;
   logic [15:0]            udp_length_ff, udp_length_in;
   logic [15:0]            payload_count_ff, payload_count_in;
   logic                   rejected_ff, rejected_in;

   logic [3:0]             link_bytes;
   logic [OffsetWidth-1:0] rel;
   logic [OffsetWidth-1:0] udp_off;
   logic [15:0]            want;
   logic [15:0]            count_next;
   logic                   frame_end;
   logic                   done;
   logic                   emit;
   logic                   last;
   logic                   short_end;
   logic [7:0]             b;

   always_comb begin
      case (link_kind_ff)
         LinkLoopback: link_bytes = LinkBytesLoopback;
         LinkEthernet: link_bytes = LinkBytesEthernet;
         default:      link_bytes = 4'd0;
      endcase
   end

   assign b          = req_data.in_byte;
   assign frame_end  = req_data.in_frame_end || ({1'b0, byte_offset_ff} >= EndOffset);
   assign rel        = byte_offset_ff - OffsetWidth'(link_bytes);
   assign udp_off    = rel - OffsetWidth'(ip_hdr_bytes_ff);
   assign want       = udp_length_ff - UdpHdrBytes;
   assign count_next = payload_count_ff + 16'd1;
   assign done       = (count_next == want);

   always_comb begin
      byte_offset_in   = byte_offset_ff;
      ip_hdr_bytes_in  = ip_hdr_bytes_ff;
      udp_length_in    = udp_length_ff;
      payload_count_in = payload_count_ff;
      rejected_in      = rejected_ff;
      emit             = 1'b0;
      last             = 1'b0;
      short_end        = 1'b0;

      if (!rejected_ff) begin
         if (byte_offset_ff >= OffsetWidth'(link_bytes)) begin
            if (rel == IpVerOffset) begin
               if (b[7:4] != IpVersion4 || b[3:0] < IhlMin) begin
                  rejected_in = 1'b1;
               end else begin
                  ip_hdr_bytes_in = {b[3:0], 2'b00};
               end
            end else if (rel == IpProtoOffset) begin
               if (b != ProtoUdp) begin
                  rejected_in = 1'b1;
               end
            end else if (ip_hdr_bytes_ff != 6'd0 &&
                         rel >= OffsetWidth'(ip_hdr_bytes_ff)) begin
               if (udp_off == UdpLenHiOff) begin
                  udp_length_in = {b, 8'h00};
               end else if (udp_off == UdpLenLoOff) begin
                  udp_length_in = udp_length_ff | {8'h00, b};
                  if ((udp_length_ff | {8'h00, b}) <= UdpHdrBytes) begin
                     rejected_in = 1'b1;
                  end
               end else if (udp_off >= UdpHdrBytes) begin
                  if (udp_length_ff > UdpHdrBytes && payload_count_ff < want) begin
                     payload_count_in = count_next;
                     emit             = 1'b1;
                     last             = done || frame_end;
                     short_end        = !done && frame_end;
                     if (done) begin
                        rejected_in = 1'b1;
                     end
                  end else begin
                     rejected_in = 1'b1;
                  end
               end
            end
         end
         if (byte_offset_ff != OffsetMax) begin
            byte_offset_in = byte_offset_ff + OffsetWidth'(1);
         end
      end

      if (req_data.in_frame_end) begin
         byte_offset_in   = '0;
         ip_hdr_bytes_in  = '0;
         udp_length_in    = '0;
         payload_count_in = '0;
         rejected_in      = 1'b0;
      end else if (frame_end) begin
         rejected_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_kind_ff     <= LinkReset;
         byte_offset_ff   <= '0;
         ip_hdr_bytes_ff  <= '0;
         udp_length_ff    <= '0;
         payload_count_ff <= '0;
         rejected_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            link_kind_ff <= csr_write_data;
         end
         if (accept) begin
            byte_offset_ff   <= byte_offset_in;
            ip_hdr_bytes_ff  <= ip_hdr_bytes_in;
            udp_length_ff    <= udp_length_in;
            payload_count_ff <= payload_count_in;
            rejected_ff      <= rejected_in;
         end
      end
   end

   assign push                    = accept && emit;
   assign push_data.payload_byte  = b;
   assign push_data.payload_last  = last;
   assign push_data.payload_short = short_end;

endmodule

// ----- src/upe_queue.sv -----
// Short FIFO of payload bytes between front end and output stage.
`timescale 1ns / 1ps

module upe_queue import upe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    not_empty,
   output logic    not_full,
   output rsp_type head
);

   rsp_type              entry_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrW:0]   count_ff;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != (QueuePtrW + 1)'(QueueDepth));
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QueuePtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueuePtrW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (QueuePtrW + 1)'(1);
            2'b01:   count_ff <= count_ff - (QueuePtrW + 1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- src/upe_back.sv -----
// Output stage: registered response holding a byte until the sink takes it.
`timescale 1ns / 1ps

module upe_back import upe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_not_empty,
   input  rsp_type q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;
   logic    load;

   assign load  = q_not_empty && (!valid_ff || rsp_ready);
   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= q_head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- src/udp_payload_extractor.sv -----
// Top level of the UDP payload extractor: front end, queue and output stage.
//
//   port group  direction  handshake            carries
//   req_*       in         req_valid/req_ready  frame byte, frame end flag
//   rsp_*       out        rsp_valid/rsp_ready  payload byte, last, short
//   csr_*       in         csr_write_enable     link_kind (2 bits)
//
// One frame byte per cycle is taken while the queue has room; header checks
// and offset tracking finish in the cycle of the transfer.
// A payload byte is written into the queue at its transfer and is then loaded
// into the output register once that register is empty or being taken.
// A stalled sink fills the four-entry queue before req_ready drops.
// Synchronous reset clears frame state and sets link_kind to Ethernet.
`timescale 1ns / 1ps

module udp_payload_extractor import upe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   logic    accept;
   logic    push;
   rsp_type push_data;
   logic    pop;
   logic    q_not_empty;
   logic    q_not_full;
   rsp_type q_head;

   assign req_ready = q_not_full;
   assign accept    = req_valid && q_not_full;

   upe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_data         (req_data),
      .push             (push),
      .push_data        (push_data)
   );

   upe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (q_not_empty),
      .not_full  (q_not_full),
      .head      (q_head)
   );

   upe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
